/* rtl/core/cbc_pkg.sv */
package cbc_pkg;

  // Outer speed loop runs once every OuterDivide samples (range 1 to 7)
  localparam logic [2:0] OuterDivide = 3'd5;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned StepWidth = 5;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgAngleGainP     = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgAngleGainBoost = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgAngleGainI     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgAngleGainD     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgSpeedGainP     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgSpeedGainI     = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgZeroTilt       = 3'd6;

  // Request opcodes
  localparam logic OpCommand = 1'b0;
  localparam logic OpSample  = 1'b1;

  // Remote command codes
  localparam logic [7:0] CmdHalt      = 8'd0;
  localparam logic [7:0] CmdStart     = 8'd1;
  localparam logic [7:0] CmdStop      = 8'd2;
  localparam logic [7:0] CmdSpdTrimUp = 8'd3;
  localparam logic [7:0] CmdSpdTrimDn = 8'd4;
  localparam logic [7:0] CmdTrnTrimUp = 8'd5;
  localparam logic [7:0] CmdTrnTrimDn = 8'd6;
  localparam logic [7:0] CmdTrimClear = 8'd7;
  localparam logic [7:0] CmdForward   = 8'd10;
  localparam logic [7:0] CmdBackward  = 8'd11;
  localparam logic [7:0] CmdSpinLeft  = 8'd12;
  localparam logic [7:0] CmdSpinRight = 8'd13;
  localparam logic [7:0] CmdArcRight  = 8'd14;
  localparam logic [7:0] CmdArcLeft   = 8'd15;
  localparam logic [7:0] CmdStill     = 8'd16;

  // Motor drive codes
  localparam logic [1:0] DriveOff = 2'd0;
  localparam logic [1:0] DriveFwd = 2'd1;
  localparam logic [1:0] DriveRev = 2'd2;

  // Sequencer steps (controller state and datapath command)
  localparam logic [StepWidth-1:0] StIdle   = 5'd0;
  localparam logic [StepWidth-1:0] StDecode = 5'd1;
  localparam logic [StepWidth-1:0] StBase   = 5'd2;
  localparam logic [StepWidth-1:0] StO1     = 5'd3;
  localparam logic [StepWidth-1:0] StO2     = 5'd4;
  localparam logic [StepWidth-1:0] StO3     = 5'd5;
  localparam logic [StepWidth-1:0] StO4     = 5'd6;
  localparam logic [StepWidth-1:0] StO5     = 5'd7;
  localparam logic [StepWidth-1:0] StO6     = 5'd8;
  localparam logic [StepWidth-1:0] StO7     = 5'd9;
  localparam logic [StepWidth-1:0] StO8     = 5'd10;
  localparam logic [StepWidth-1:0] StO9     = 5'd11;
  localparam logic [StepWidth-1:0] StO10    = 5'd12;
  localparam logic [StepWidth-1:0] StO11    = 5'd13;
  localparam logic [StepWidth-1:0] StI1     = 5'd14;
  localparam logic [StepWidth-1:0] StI2     = 5'd15;
  localparam logic [StepWidth-1:0] StI3     = 5'd16;
  localparam logic [StepWidth-1:0] StI4     = 5'd17;
  localparam logic [StepWidth-1:0] StI5     = 5'd18;
  localparam logic [StepWidth-1:0] StI6     = 5'd19;
  localparam logic [StepWidth-1:0] StI7     = 5'd20;
  localparam logic [StepWidth-1:0] StI8     = 5'd21;
  localparam logic [StepWidth-1:0] StI9     = 5'd22;
  localparam logic [StepWidth-1:0] StI10    = 5'd23;
  localparam logic [StepWidth-1:0] StI11    = 5'd24;
  localparam logic [StepWidth-1:0] StI12    = 5'd25;
  localparam logic [StepWidth-1:0] StI13    = 5'd26;
  localparam logic [StepWidth-1:0] StI14    = 5'd27;

  typedef struct packed {
    logic [StepWidth-1:0] step;
    logic                 capture;
  } cbc_cmd_t;

  typedef struct packed {
    logic sample;
    logic outer_due;
  } cbc_status_t;

endpackage

/* rtl/core/cbc_if.sv */
interface cbc_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         command;
  logic signed [15:0] tilt_angle;
  logic signed [31:0] left_count;
  logic [15:0]        right_count;

  modport source (output valid, opcode, command, tilt_angle, left_count, right_count,
                  input ready);
  modport sink (input valid, opcode, command, tilt_angle, left_count, right_count,
                output ready);
endinterface

interface cbc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] left_duty;
  logic [1:0]  left_drive;
  logic [10:0] right_duty;
  logic [1:0]  right_drive;
  logic        motors_enabled;

  modport source (output valid, left_duty, left_drive, right_duty, right_drive,
                  motors_enabled, input ready);
  modport sink (input valid, left_duty, left_drive, right_duty, right_drive,
                motors_enabled, output ready);
endinterface

/* rtl/core/cbc_ctrl.sv */
module cbc_ctrl import cbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  cbc_status_t status_i,
  output cbc_cmd_t    cmd_o
);

  logic [StepWidth-1:0] state_d, state_q;
  logic                 out_valid_d, out_valid_q;
  logic                 out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cmd_o.step    = state_q;
  assign cmd_o.capture = in_ready_o && in_valid_i;

  // Step sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StDecode;
      StDecode: state_d = status_i.sample ? StBase : StIdle;
      StBase:   state_d = status_i.outer_due ? StO1 : StI1;
      StO11:    state_d = StI1;
      // hold before the result step until the output register is free
      StI13:    if (out_free) state_d = StI14;
      StI14:    state_d = StIdle;
      default:  state_d = state_q + 5'd1;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == StI14) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/cbc_datapath.sv */
module cbc_datapath import cbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   opcode_i,
  input  logic [7:0]             command_i,
  input  logic signed [15:0]     tilt_angle_i,
  input  logic signed [31:0]     left_count_i,
  input  logic [15:0]            right_count_i,
  input  cbc_cmd_t               cmd_i,
  output cbc_status_t            status_o,
  output logic [10:0]            left_duty_o,
  output logic [1:0]             left_drive_o,
  output logic [10:0]            right_duty_o,
  output logic [1:0]             right_drive_o,
  output logic                   motors_enabled_o
);

  typedef struct packed {
    logic [10:0] duty;
    logic [1:0]  drive;
  } motor_t;

  localparam logic signed [67:0] One       = 68'sd65536;
  localparam logic signed [67:0] SpdTrimHi = 68'sd5242880;
  localparam logic signed [67:0] SpdTrimLo = -68'sd4259840;
  localparam logic signed [67:0] TrnTrimHi = 68'sd2621440;
  localparam logic signed [67:0] TrnTrimLo = -68'sd1638400;
  localparam logic [32:0]        DivMagic  = 33'h0_51EB_851F;  // ceil(2^35 / 25)

  function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] x,
                                                 input int unsigned s);
    rnd_shr = (x + (68'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [67:0] clamp(input logic signed [67:0] x,
                                               input logic signed [67:0] lo,
                                               input logic signed [67:0] hi);
    if (x < lo) clamp = lo;
    else if (x > hi) clamp = hi;
    else clamp = x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [67:0] c;
    c = clamp(x, -68'sd2147483648, 68'sd2147483647);
    sat32 = c[31:0];
  endfunction

  // duty with deadzone offset for one motor
  function automatic motor_t motor(input logic signed [57:0] x, input logic [6:0] minp);
    logic [57:0] a;
    logic [41:0] hi;
    logic [24:0] lo;
    logic [42:0] p;
    motor_t      m;
    a  = x[57] ? 58'(-x) : 58'(x);
    hi = a[57:16];
    lo = 25'(a[16:0]) * 25'({7'd0, minp, 1'b1});
    if (a > 58'd32768) p = 43'(hi) + 43'(minp);
    else p = 43'(lo[24:16]);
    if (p > 43'd1199) p = 43'd1199;
    if (x > 58'sd6553) begin
      m.duty = p[10:0]; m.drive = DriveFwd;
    end else if (x < -58'sd6553) begin
      m.duty = p[10:0]; m.drive = DriveRev;
    end else begin
      m.duty = 11'd0; m.drive = DriveOff;
    end
    motor = m;
  endfunction

  // configuration
  logic [15:0]        gain_p_q, gain_boost_q, gain_i_q, gain_d_q, spd_gain_p_q, spd_gain_i_q;
  logic signed [12:0] zero_tilt_q;
  // controller state
  logic               running_q, baseline_q;
  logic signed [31:0] speed_target_q, turn_rate_q, speed_trim_q, turn_trim_q;
  logic [2:0]         tick_q;
  logic [31:0]        last_left_q;
  logic [15:0]        last_right_q;
  logic signed [31:0] spd_filt_q, spd_ramp_q, spd_int_q, prev_target_q;
  logic signed [31:0] tilt_goal_q, tilt_set_q, last_err_q, ang_int_q;
  // captured request
  logic               op_q;
  logic [7:0]         cmd_q;
  logic signed [15:0] tilt_q;
  logic [31:0]        left_q;
  logic [15:0]        right_q;
  // work registers
  logic signed [32:0] dsum_q;
  logic signed [67:0] prod_q, acc_q;
  logic signed [31:0] vel_q, serr_q, pterm_q;
  logic signed [33:0] sp_q, sq_q;
  logic signed [32:0] err_q;
  logic signed [55:0] dterm_q;
  logic               neg_q;
  logic [31:0]        udiv_q;
  logic signed [57:0] mot_l_q, mot_r_q;
  // result register
  logic [10:0]        left_duty_q, right_duty_q;
  logic [1:0]         left_drive_q, right_drive_q;
  logic               enabled_q;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_d;

  // encoder deltas
  logic [2:0]         tick_nx;
  logic [31:0]        eff_left;
  logic [15:0]        eff_right;
  logic signed [31:0] d_left;
  logic signed [16:0] d_right;
  logic signed [32:0] dsum_d;

  // combinational helpers
  logic signed [67:0] tilt68, zt68, sum_ap, r16_p, r16_ap, r8_ap;
  logic signed [67:0] serr_full, sp3, sp_d, spi_d, goal_d, err_full;
  logic signed [67:0] p100, dterm_d, xdiv, qdiv, udiv_d, quot, inc, aint_d;
  logic signed [67:0] pid, mot_l_d, mot_r_d, pclamp;
  logic signed [31:0] serr_d;
  logic signed [33:0] err34, diff34;
  logic               sign_flip, tilt_big;
  logic signed [67:0] spd_trim_up, spd_trim_dn, trn_trim_up, trn_trim_dn;
  motor_t             mot_l, mot_r;

  assign tick_nx   = tick_q + 3'd1;
  assign eff_left  = baseline_q ? last_left_q : left_q;
  assign eff_right = baseline_q ? last_right_q : right_q;
  assign d_left    = $signed(left_q - eff_left);
  assign d_right   = $signed({eff_right[15], eff_right}) - $signed({right_q[15], right_q});
  assign dsum_d    = 33'(d_left) + 33'(d_right);

  assign status_o.sample    = (op_q == OpSample);
  assign status_o.outer_due = (tick_nx >= OuterDivide);

  assign tilt68   = 68'(tilt_q) <<< 8;
  assign zt68     = 68'(zero_tilt_q) <<< 8;
  assign sum_ap   = acc_q + prod_q;
  assign r16_p    = rnd_shr(prod_q, 16);
  assign r16_ap   = rnd_shr(sum_ap, 16);
  assign r8_ap    = rnd_shr(sum_ap, 8);
  assign tilt_big = (tilt_q > 16'sd5120) || (tilt_q < -16'sd5120);
  assign err34    = 34'(err_q);
  assign diff34   = err34 - 34'(last_err_q);

  // outer loop pieces
  always_comb begin
    serr_full = 68'(spd_ramp_q) - 68'(spd_filt_q);
    serr_d    = sat32(serr_full);
    if (speed_target_q == 32'sd0) begin
      if (serr_d > -32'sd98304 && serr_d < 32'sd98304) serr_d = 32'sd0;
    end else begin
      if (serr_d > -32'sd327680 && serr_d < 32'sd327680) serr_d = 32'sd0;
    end
    sp3    = prod_q + (prod_q <<< 1);
    sp_d   = (speed_target_q == 32'sd0) ? rnd_shr(sp3, 17) : r16_p;
    spi_d  = clamp(68'(spd_int_q) + r16_p, -3 * One, 3 * One);
    goal_d = clamp(zt68 + 68'(sp_q) + 68'(spd_int_q), zt68 - 7 * One, zt68 + 7 * One);
  end

  // inner loop pieces
  always_comb begin
    err_full  = tilt68 - 68'(tilt_set_q);
    pclamp    = clamp(r8_ap, -900 * One, 900 * One);
    p100      = (prod_q <<< 6) + (prod_q <<< 5) + (prod_q <<< 2);
    dterm_d   = rnd_shr(p100, 8);
    // divide by 25600 rounded to nearest: add 12800, shift by 1024, then floor divide by 25
    xdiv      = prod_q + 68'sd12800;
    qdiv      = xdiv >>> 10;
    udiv_d    = (qdiv < 0) ? (68'sd24 - qdiv) : qdiv;
    quot      = {36'd0, prod_q[66:35]};
    inc       = neg_q ? -quot : quot;
    aint_d    = clamp(68'(ang_int_q) + inc, -300 * One, 300 * One);
    sign_flip = (err_q < 0 && last_err_q > 0) || (err_q > 0 && last_err_q < 0);
    pid       = 68'(pterm_q) + 68'(ang_int_q) + 68'(dterm_q);
    mot_l_d   = pid + 68'(turn_rate_q);
    mot_r_d   = pid - 68'(turn_rate_q);
    mot_l     = motor(mot_l_q, 7'd33);
    mot_r     = motor(mot_r_q, 7'd30);
  end

  // trim steps
  always_comb begin
    spd_trim_up = clamp(68'(speed_trim_q) + 5 * One, SpdTrimLo, SpdTrimHi);
    spd_trim_dn = clamp(68'(speed_trim_q) - 5 * One, SpdTrimLo, SpdTrimHi);
    trn_trim_up = clamp(68'(turn_trim_q) + 5 * One, TrnTrimLo, TrnTrimHi);
    trn_trim_dn = clamp(68'(turn_trim_q) - 5 * One, TrnTrimLo, TrnTrimHi);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      StO1:  begin mul_a = 34'(dsum_q);         mul_b = 34'sd88015; end
      StO2:  begin mul_a = 34'(spd_filt_q);     mul_b = 34'sd52429; end
      StO3:  begin mul_a = 34'(vel_q);          mul_b = 34'sd13107; end
      StO4:  begin mul_a = 34'(spd_ramp_q);     mul_b = 34'sd58982; end
      StO5:  begin mul_a = 34'(speed_target_q); mul_b = 34'sd6554;  end
      StO8:  begin mul_a = 34'(serr_q);         mul_b = $signed({18'd0, spd_gain_p_q}); end
      StO9:  begin mul_a = 34'(serr_q);         mul_b = $signed({18'd0, spd_gain_i_q}); end
      StI1:  begin mul_a = 34'(tilt_set_q);     mul_b = 34'sd39322; end
      StI2:  begin mul_a = 34'(tilt_goal_q);    mul_b = 34'sd26214; end
      StI5:  begin mul_a = err34;               mul_b = err_q[32] ? -err34 : err34; end
      StI6:  begin mul_a = err34;               mul_b = $signed({18'd0, gain_p_q}); end
      StI7:  begin mul_a = sq_q;                mul_b = $signed({18'd0, gain_boost_q}); end
      StI8:  begin mul_a = diff34;              mul_b = $signed({18'd0, gain_d_q}); end
      StI9:  begin mul_a = err34;               mul_b = $signed({18'd0, gain_i_q}); end
      StI11: begin mul_a = $signed({2'd0, udiv_q}); mul_b = $signed({1'b0, DivMagic}); end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // work and request registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      cmd_q   <= command_i;
      tilt_q  <= tilt_angle_i;
      left_q  <= left_count_i;
      right_q <= right_count_i;
    end
    unique case (cmd_i.step)
      StBase: dsum_q <= dsum_d;
      StO2:   vel_q <= sat32(prod_q);
      StO3:   acc_q <= prod_q;
      StO5:   acc_q <= prod_q;
      StO7:   serr_q <= serr_d;
      StO9:   sp_q <= sp_d[33:0];
      StI2:   acc_q <= prod_q;
      StI4:   err_q <= err_full[32:0];
      StI6:   sq_q <= r16_p[33:0];
      StI7:   acc_q <= prod_q;
      StI8:   pterm_q <= pclamp[31:0];
      StI9:   dterm_q <= dterm_d[55:0];
      StI10: begin
        neg_q  <= (qdiv < 0);
        udiv_q <= udiv_d[31:0];
      end
      StI13: begin
        mot_l_q <= mot_l_d[57:0];
        mot_r_q <= mot_r_d[57:0];
      end
      StI14: begin
        left_duty_q   <= running_q ? mot_l.duty : 11'd0;
        left_drive_q  <= running_q ? mot_l.drive : DriveOff;
        right_duty_q  <= running_q ? mot_r.duty : 11'd0;
        right_drive_q <= running_q ? mot_r.drive : DriveOff;
        enabled_q     <= running_q;
      end
      default: ;
    endcase
  end

  // configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= 16'd8960;
      gain_boost_q   <= 16'd3840;
      gain_i_q       <= 16'd46080;
      gain_d_q       <= 16'd128;
      spd_gain_p_q   <= 16'd1311;
      spd_gain_i_q   <= 16'd66;
      zero_tilt_q    <= 13'sd256;
      running_q      <= 1'b0;
      baseline_q     <= 1'b0;
      speed_target_q <= '0;
      turn_rate_q    <= '0;
      speed_trim_q   <= '0;
      turn_trim_q    <= '0;
      tick_q         <= '0;
      last_left_q    <= '0;
      last_right_q   <= '0;
      spd_filt_q     <= '0;
      spd_ramp_q     <= '0;
      spd_int_q      <= '0;
      prev_target_q  <= '0;
      tilt_goal_q    <= 32'sd65536;
      tilt_set_q     <= 32'sd32768;
      last_err_q     <= '0;
      ang_int_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgAngleGainP:     gain_p_q     <= cfg_data_i;
          CfgAngleGainBoost: gain_boost_q <= cfg_data_i;
          CfgAngleGainI:     gain_i_q     <= cfg_data_i;
          CfgAngleGainD:     gain_d_q     <= cfg_data_i;
          CfgSpeedGainP:     spd_gain_p_q <= cfg_data_i;
          CfgSpeedGainI:     spd_gain_i_q <= cfg_data_i;
          CfgZeroTilt:       zero_tilt_q  <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      unique case (cmd_i.step)
        // remote commands
        StDecode: begin
          if (op_q == OpCommand) begin
            unique case (cmd_q)
              CmdHalt: begin
                speed_target_q <= '0;
                turn_rate_q    <= '0;
                spd_int_q      <= '0;
              end
              CmdStart:     running_q    <= 1'b1;
              CmdStop:      running_q    <= 1'b0;
              CmdSpdTrimUp: speed_trim_q <= spd_trim_up[31:0];
              CmdSpdTrimDn: speed_trim_q <= spd_trim_dn[31:0];
              CmdTrnTrimUp: turn_trim_q  <= trn_trim_up[31:0];
              CmdTrnTrimDn: turn_trim_q  <= trn_trim_dn[31:0];
              CmdTrimClear: begin
                speed_trim_q <= '0;
                turn_trim_q  <= '0;
              end
              CmdForward: begin
                speed_target_q <= 32'sd5242880 + speed_trim_q;
                turn_rate_q    <= '0;
              end
              CmdBackward: begin
                speed_target_q <= -32'sd5242880 - speed_trim_q;
                turn_rate_q    <= '0;
              end
              CmdSpinLeft: begin
                speed_target_q <= '0;
                turn_rate_q    <= -32'sd2621440 - turn_trim_q;
              end
              CmdSpinRight: begin
                speed_target_q <= '0;
                turn_rate_q    <= 32'sd2621440 + turn_trim_q;
              end
              CmdArcRight: begin
                speed_target_q <= 32'sd5242880;
                turn_rate_q    <= 32'sd1310720;
              end
              CmdArcLeft: begin
                speed_target_q <= 32'sd5242880;
                turn_rate_q    <= -32'sd1310720;
              end
              CmdStill: begin
                speed_target_q <= '0;
                turn_rate_q    <= '0;
              end
              default: ;
            endcase
          end
        end
        // encoder baseline and outer tick
        StBase: begin
          baseline_q <= 1'b1;
          if (!baseline_q || status_o.outer_due) begin
            last_left_q  <= left_q;
            last_right_q <= right_q;
          end
          tick_q <= status_o.outer_due ? 3'd0 : tick_nx;
        end
        StO4: spd_filt_q <= r16_ap[31:0];
        StO6: spd_ramp_q <= (speed_target_q == 32'sd0) ? 32'sd0 : r16_ap[31:0];
        StO7: if (speed_target_q == 32'sd0 && prev_target_q != 32'sd0) spd_int_q <= '0;
        StO10: spd_int_q <= tilt_big ? 32'sd0 : spi_d[31:0];
        StO11: tilt_goal_q <= goal_d[31:0];
        StI3:  tilt_set_q <= r16_ap[31:0];
        StI12: begin
          if (running_q) begin
            ang_int_q <= sign_flip ? 32'sd0 : aint_d[31:0];
          end else begin
            ang_int_q <= '0;
            spd_int_q <= '0;
          end
        end
        StI14: begin
          last_err_q    <= sat32(68'(err_q));
          prev_target_q <= speed_target_q;
        end
        default: ;
      endcase
    end
  end

  assign left_duty_o      = left_duty_q;
  assign left_drive_o     = left_drive_q;
  assign right_duty_o     = right_duty_q;
  assign right_drive_o    = right_drive_q;
  assign motors_enabled_o = enabled_q;

endmodule

/* rtl/core/cascade_balance_controller_unit.sv */
// Channel  | Dir | Handshake     | Payload
// req_i    | in  | valid / ready | opcode, command, tilt_angle, left_count, right_count
// rsp_o    | out | valid / ready | left_duty, left_drive, right_duty, right_drive,
//          |     |               | motors_enabled
// cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// A command request is handled in the decode step. A sample request runs the inner
// loop steps, with the outer speed loop steps first on every fifth sample; the
// sequencer steps the single shared 34x34 multiplier through the loop math.
// Reset restores gains and loop state; no clearing pass is needed.
// A result waits in the output register while the next request is accepted; a
// sample stalls before its result step only while the previous result is still held.
module cascade_balance_controller_unit import cbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  cbc_in_if.sink                 req_i,
  cbc_out_if.source              rsp_o
);

  cbc_cmd_t    cmd;
  cbc_status_t status;

  cbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (req_i.opcode),
    .command_i        (req_i.command),
    .tilt_angle_i     (req_i.tilt_angle),
    .left_count_i     (req_i.left_count),
    .right_count_i    (req_i.right_count),
    .cmd_i            (cmd),
    .status_o         (status),
    .left_duty_o      (rsp_o.left_duty),
    .left_drive_o     (rsp_o.left_drive),
    .right_duty_o     (rsp_o.right_duty),
    .right_drive_o    (rsp_o.right_drive),
    .motors_enabled_o (rsp_o.motors_enabled)
  );

endmodule
